/* design/pst_pkg.sv */
// Shared types and constants for the PID steering and throttle controller.
package pst_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  typedef enum logic [1:0] {
    REG_GAIN_PROP  = 2'd0,
    REG_GAIN_INTEG = 2'd1,
    REG_GAIN_DERIV = 2'd2
  } pst_reg_t;

  typedef struct packed {
    logic signed [15:0] error_sample;
    logic signed [15:0] throttle_req;
  } pst_in_t;

  typedef struct packed {
    logic signed [15:0] steering;
    logic        [14:0] throttle;
  } pst_out_t;

  typedef struct packed {
    logic signed [15:0] gain_prop;
    logic signed [15:0] gain_integ;
    logic signed [15:0] gain_deriv;
  } pst_gains_t;

  typedef struct packed {
    logic signed [15:0] err;
    logic signed [16:0] diff;
    logic signed [31:0] sum;
    logic signed [15:0] goal;
  } pst_work_t;

endpackage

/* design/pst_front.sv */
// Front end: accepts items, updates the error history and the saturating error sum.
module pst_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pst_pkg::pst_in_t  in_data,
  input  logic              q_full,
  output logic              q_push,
  output pst_pkg::pst_work_t q_data
);
  import pst_pkg::*;

  logic signed [15:0] last_error_r, last_error_nxt;
  logic signed [31:0] error_sum_r, error_sum_nxt;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic               accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  always_comb begin
    sum_wide = 33'(error_sum_r) + 33'(in_data.error_sample);
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  always_comb begin
    q_data.err  = in_data.error_sample;
    q_data.diff = 17'(in_data.error_sample) - 17'(last_error_r);
    q_data.sum  = sum_sat;
    q_data.goal = in_data.throttle_req;
  end

  always_comb begin
    last_error_nxt = last_error_r;
    error_sum_nxt  = error_sum_r;
    if (accept) begin
      last_error_nxt = in_data.error_sample;
      error_sum_nxt  = sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      error_sum_r  <= '0;
    end else begin
      last_error_r <= last_error_nxt;
      error_sum_r  <= error_sum_nxt;
    end
  end

endmodule

/* design/pst_queue.sv */
// Short first-in first-out queue between the front end and the arithmetic back end.
module pst_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pst_pkg::pst_work_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               avail,
  output pst_pkg::pst_work_t pop_data
);
  import pst_pkg::*;

  pst_work_t        mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCntW'(QDepth));
  assign avail    = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPtrW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPtrW'(1) : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCntW'(1);
      2'b01:   cnt_nxt = cnt_r - QCntW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* design/pst_back.sv */
// Back end: three-stage pipeline of gain products, sums, and rounding with saturation.
module pst_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pst_pkg::pst_gains_t gains,
  input  logic                work_avail,
  input  pst_pkg::pst_work_t  work,
  output logic                work_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pst_pkg::pst_out_t   out_data
);
  import pst_pkg::*;

  logic               s1_valid_r, s1_valid_nxt;
  logic signed [31:0] s1_kpe_r;
  logic signed [32:0] s1_kdd_r;
  logic signed [47:0] s1_kis_r;
  logic signed [15:0] s1_goal_r;

  logic               s2_valid_r, s2_valid_nxt;
  logic signed [48:0] s2_total_r;
  logic signed [34:0] s2_thr_r;

  logic               out_valid_r, out_valid_nxt;
  pst_out_t           out_data_r;

  logic               out_rdy, s2_rdy, s1_rdy;
  logic signed [31:0] kpe;
  logic signed [32:0] kdd;
  logic signed [47:0] kis;
  logic signed [48:0] total_nxt;
  logic signed [34:0] thr_nxt;
  logic signed [49:0] st_full;
  logic signed [37:0] st_q;
  logic signed [35:0] th_full;
  logic signed [23:0] th_q;
  logic signed [24:0] th_abs;
  pst_out_t           res;

  assign out_rdy  = !out_valid_r || !out_stall;
  assign s2_rdy   = !s2_valid_r || out_rdy;
  assign s1_rdy   = !s1_valid_r || s2_rdy;
  assign work_pop = work_avail && s1_rdy;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign kpe = gains.gain_prop * work.err;
  assign kdd = 33'(gains.gain_deriv) * 33'(work.diff);
  assign kis = 48'(gains.gain_integ) * 48'(work.sum);

  always_comb begin
    total_nxt = 49'(s1_kpe_r) + 49'(s1_kdd_r) + 49'(s1_kis_r);
    thr_nxt   = $signed({{7{s1_goal_r[15]}}, s1_goal_r, 12'd0})
                - 35'(s1_kpe_r) - 35'(s1_kdd_r);
  end

  always_comb begin
    st_full = 50'sd2048 - 50'(s2_total_r);
    st_q    = st_full[49:12];
    if (st_q > 38'sd32767) begin
      res.steering = 16'sh7FFF;
    end else if (st_q < -38'sd32768) begin
      res.steering = 16'sh8000;
    end else begin
      res.steering = st_q[15:0];
    end

    th_full = 36'(s2_thr_r) + 36'sd2048;
    th_q    = th_full[35:12];
    th_abs  = th_q[23] ? -25'(th_q) : 25'(th_q);
    if (th_abs > 25'sd32767) begin
      res.throttle = 15'h7FFF;
    end else begin
      res.throttle = th_abs[14:0];
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_rdy ? work_avail : s1_valid_r;
    s2_valid_nxt  = s2_rdy ? s1_valid_r : s2_valid_r;
    out_valid_nxt = out_rdy ? s2_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && work_avail) begin
      s1_kpe_r  <= kpe;
      s1_kdd_r  <= kdd;
      s1_kis_r  <= kis;
      s1_goal_r <= work.goal;
    end
    if (s2_rdy && s1_valid_r) begin
      s2_total_r <= total_nxt;
      s2_thr_r   <= thr_nxt;
    end
    if (out_rdy && s2_valid_r) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* design/pid_steering_throttle.sv */
// Top level of the PID steering and throttle controller with its gain registers.
//
//   Channel  Ports                                Direction  Carries
//   in       in_valid, in_stall, in_data          in         error sample, goal throttle
//   out      out_valid, out_stall, out_data       out        steering, throttle
//   cfg      cfg_we, cfg_index, cfg_wdata         in         Kp, Ki, Kd gains
//
// One item is taken per cycle while the queue is not full; an accepted item is
// registered in the queue entry and the back end's product, sum and rounding stages.
// Reset clears the error history, the error sum, the gains and all valid flags.
// A stalled output holds the back end; the front end keeps taking items until the
// four-entry queue between them is full.
module pid_steering_throttle (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pst_pkg::pst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pst_pkg::pst_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);
  import pst_pkg::*;

  pst_gains_t gains_r, gains_nxt;
  logic       q_full, q_push, q_avail, q_pop;
  pst_work_t  q_wdata, q_rdata;

  always_comb begin
    gains_nxt = gains_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_PROP:  gains_nxt.gain_prop  = cfg_wdata;
        REG_GAIN_INTEG: gains_nxt.gain_integ = cfg_wdata;
        REG_GAIN_DERIV: gains_nxt.gain_deriv = cfg_wdata;
        default:        gains_nxt = gains_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
    end else begin
      gains_r <= gains_nxt;
    end
  end

  pst_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  pst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_rdata)
  );

  pst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .gains      (gains_r),
    .work_avail (q_avail),
    .work       (q_rdata),
    .work_pop   (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
